// ===== rtl/gnts_pkg.sv =====
package gnts_pkg;

  // Field widths
  localparam int RpmW    = 20;
  localparam int MaxRpmW = 19;
  localparam int StepW   = 16;
  localparam int SpdW    = 16;
  localparam int ThrW    = 16;
  localparam int SmW     = 24;

  // Configuration port
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 19;

  // Datapath widths
  localparam int DenW  = MaxRpmW + 4;   // full scale in 256ths of an rpm
  localparam int SpanW = StepW + 1;     // max_steps - min_steps
  localparam int MulAW = DenW + 1;      // signed, holds an unsigned DenW value
  localparam int MulBW = SpanW;
  localparam int ProdW = MulAW + MulBW;
  localparam int AccW  = ProdW + 1;
  localparam int MagW  = AccW - 1;
  localparam int NumW  = MagW + 1;      // 2*|n| + den
  localparam int DivW  = DenW + 1;      // 2*den
  localparam int QuoW  = StepW + 1;     // quotient never exceeds 2**StepW - 1
  localparam int CntW  = $clog2(QuoW);

  // Reset values of the configuration registers
  localparam logic [MaxRpmW-1:0]      MaxRpmRst    = MaxRpmW'(128000);
  localparam logic signed [StepW-1:0] MinStepsRst  = StepW'(0);
  localparam logic signed [StepW-1:0] MaxStepsRst  = StepW'(3780);
  localparam logic [ThrW-1:0]         JumpThrRst   = ThrW'(35);
  localparam logic [SpdW-1:0]         NormSpeedRst = SpdW'(1000);
  localparam logic [SpdW-1:0]         FastSpeedRst = SpdW'(4000);

  typedef enum logic [CfgAddrW-1:0] {
    REG_MAX_RPM    = 3'd0,
    REG_MIN_STEPS  = 3'd1,
    REG_MAX_STEPS  = 3'd2,
    REG_JUMP_THR   = 3'd3,
    REG_NORM_SPEED = 3'd4,
    REG_FAST_SPEED = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/gnts_in_if.sv =====
interface gnts_in_if import gnts_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [RpmW-1:0]    rpm_reading;
  logic                      reading_invalid;
  logic signed [StepW-1:0]   motor_position;

  modport source (output valid, rpm_reading, reading_invalid, motor_position, input ready);
  modport sink   (input valid, rpm_reading, reading_invalid, motor_position, output ready);
endinterface

// ===== rtl/gnts_out_if.sv =====
interface gnts_out_if import gnts_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [StepW-1:0]   target_steps;
  logic [SpdW-1:0]           move_speed;
  logic                      fast_move;

  modport source (output valid, target_steps, move_speed, fast_move, input ready);
  modport sink   (input valid, target_steps, move_speed, fast_move, output ready);
endinterface

// ===== rtl/gnts_mul.sv =====
module gnts_mul import gnts_pkg::*; (
  input  logic                    clk_i,
  input  logic signed [MulAW-1:0] a_i,
  input  logic signed [MulBW-1:0] b_i,
  output logic signed [ProdW-1:0] prod_o
);

  logic signed [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(a_i * b_i);
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/gnts_div.sv =====
module gnts_div import gnts_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DivW-1:0] den_i,
  output div_stat_t       stat_o,
  output logic [QuoW-1:0] quo_o
);

  logic [DivW-1:0] rem_q;
  logic [DivW-1:0] den_q;
  logic [QuoW-1:0] num_q;
  logic [QuoW-1:0] quo_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;

  logic [DivW:0]   trial;
  logic            fits;

  assign trial = {rem_q, num_q[QuoW-1]};
  assign fits  = trial >= {1'b0, den_q};

  // The upper numerator bits are already below the divisor, so only the
  // low QuoW bits need a restoring step each.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(QuoW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[QuoW +: DivW];
      num_q <= num_i[QuoW-1:0];
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? DivW'(trial - {1'b0, den_q}) : trial[DivW-1:0];
      num_q <= {num_q[QuoW-2:0], 1'b0};
      quo_q <= {quo_q[QuoW-2:0], fits};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;

endmodule

// ===== rtl/gauge_needle_target_smoother_core.sv =====
// Gauge needle target smoother. Each transaction on the input channel carries an rpm
// reading (signed, sixteenths of an rpm), an invalid flag and the motor position; the
// block answers with exactly one result transaction: the step target, the move speed and
// a flag that tells whether smoothing was bypassed by a large jump. The reading is
// clamped to [0, max_rpm], mapped onto [min_steps, max_steps] to test the jump, the
// smoothed rpm (8 fraction bits, alpha 1/4) is updated and mapped again to give the
// target. Both mappings run through one registered multiplier and one restoring
// divider that retires a quotient bit per cycle and runs 17 iterations per mapping. A new
// item is accepted once the sequencer is back at rest, even while the previous result
// still waits in the output register. Configuration writes are taken at any time but
// should be made while the block is idle.
module gauge_needle_target_smoother_core import gnts_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  gnts_in_if.sink             in_i,
  gnts_out_if.source          out_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_A,
    S_MUL_B,
    S_SUM,
    S_ABS,
    S_DIV_GO,
    S_DIV,
    S_JUMP,
    S_CLAMP,
    S_OUT
  } state_e;

  // Configuration registers
  logic [MaxRpmW-1:0]      max_rpm_q;
  logic signed [StepW-1:0] min_steps_q;
  logic signed [StepW-1:0] max_steps_q;
  logic [ThrW-1:0]         jump_thr_q;
  logic [SpdW-1:0]         norm_speed_q;
  logic [SpdW-1:0]         fast_speed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_rpm_q    <= MaxRpmRst;
      min_steps_q  <= MinStepsRst;
      max_steps_q  <= MaxStepsRst;
      jump_thr_q   <= JumpThrRst;
      norm_speed_q <= NormSpeedRst;
      fast_speed_q <= FastSpeedRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_MAX_RPM:    max_rpm_q    <= cfg_wdata_i;
        REG_MIN_STEPS:  min_steps_q  <= cfg_wdata_i[StepW-1:0];
        REG_MAX_STEPS:  max_steps_q  <= cfg_wdata_i[StepW-1:0];
        REG_JUMP_THR:   jump_thr_q   <= cfg_wdata_i[ThrW-1:0];
        REG_NORM_SPEED: norm_speed_q <= cfg_wdata_i[SpdW-1:0];
        REG_FAST_SPEED: fast_speed_q <= cfg_wdata_i[SpdW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and datapath registers
  state_e                   state_q;
  logic                     pass_q;
  logic [DenW-1:0]          r_q;
  logic signed [StepW-1:0]  pos_q;
  logic signed [AccW-1:0]   acc_q;
  logic [MagW-1:0]          mag_q;
  logic                     neg_q;
  logic signed [StepW-1:0]  raw_q;
  logic                     fast_q;
  logic [SmW-1:0]           smoothed_q;
  logic                     out_valid_q;
  logic signed [StepW-1:0]  out_target_q;
  logic [SpdW-1:0]          out_speed_q;
  logic                     out_fast_q;

  logic                     in_fire;
  logic                     out_free;
  logic [MaxRpmW-1:0]       clamped;
  logic [DenW-1:0]          den;
  logic signed [SpanW-1:0]  span;
  logic signed [MulAW-1:0]  mul_a;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [ProdW-1:0]  prod;
  logic                     div_start;
  logic [NumW-1:0]          div_num;
  logic [DivW-1:0]          div_den;
  div_stat_t                div_stat;
  logic [QuoW-1:0]          quo;
  logic signed [StepW-1:0]  map_res;
  logic signed [SpanW:0]    step_gap;
  logic signed [SpanW:0]    thr_pos;
  logic signed [SpanW:0]    thr_neg;
  logic                     jump;
  logic [DenW-1:0]          r16;
  logic signed [SmW:0]      sm_diff;
  logic signed [SmW:0]      sm_next;
  logic [SmW-1:0]           full16;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    if (in_i.reading_invalid || in_i.rpm_reading[RpmW-1]) begin
      clamped = '0;
    end else if (in_i.rpm_reading[MaxRpmW-1:0] > max_rpm_q) begin
      clamped = max_rpm_q;
    end else begin
      clamped = in_i.rpm_reading[MaxRpmW-1:0];
    end
  end

  // First mapping is in sixteenths against max_rpm, the second in 256ths against 16*max_rpm
  assign den  = pass_q ? {max_rpm_q, 4'b0000} : {4'b0000, max_rpm_q};
  assign span = SpanW'(max_steps_q) - SpanW'(min_steps_q);

  assign mul_a = (state_q == S_MUL_A) ? $signed({1'b0, den}) : $signed({1'b0, r_q});
  assign mul_b = (state_q == S_MUL_A) ? MulBW'(min_steps_q) : span;

  gnts_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Round half away from zero: q = (2|n| + den) / (2 den), sign restored afterwards
  assign div_start = (state_q == S_DIV_GO);
  assign div_num   = {mag_q, 1'b0} + NumW'(den);
  assign div_den   = {den, 1'b0};

  gnts_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .stat_o  (div_stat),
    .quo_o   (quo)
  );

  always_comb begin
    if (max_rpm_q == '0) begin
      map_res = min_steps_q;
    end else if (neg_q) begin
      map_res = StepW'(~quo + 1'b1);
    end else begin
      map_res = quo[StepW-1:0];
    end
  end

  assign step_gap = (SpanW+1)'(raw_q) - (SpanW+1)'(pos_q);
  assign thr_pos  = $signed({2'b00, jump_thr_q});
  assign thr_neg  = -thr_pos;
  assign jump     = (step_gap > thr_pos) || (step_gap < thr_neg);

  // Smoothing step with an arithmetic shift, which rounds toward minus infinity
  assign r16     = {r_q[MaxRpmW-1:0], 4'b0000};
  assign sm_diff = $signed({2'b00, r16}) - $signed({1'b0, smoothed_q});
  assign sm_next = $signed({1'b0, smoothed_q}) + (sm_diff >>> 2);
  assign full16  = {1'b0, max_rpm_q, 4'b0000};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass_q      <= 1'b0;
      smoothed_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            r_q     <= {4'b0000, clamped};
            pos_q   <= in_i.motor_position;
            pass_q  <= 1'b0;
            state_q <= S_MUL_A;
          end
        end
        S_MUL_A: begin
          state_q <= S_MUL_B;
        end
        S_MUL_B: begin
          acc_q   <= AccW'(prod);
          state_q <= S_SUM;
        end
        S_SUM: begin
          acc_q   <= acc_q + AccW'(prod);
          state_q <= S_ABS;
        end
        S_ABS: begin
          neg_q   <= acc_q[AccW-1];
          mag_q   <= acc_q[AccW-1] ? MagW'(-acc_q) : acc_q[MagW-1:0];
          state_q <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            raw_q   <= map_res;
            state_q <= pass_q ? S_OUT : S_JUMP;
          end
        end
        S_JUMP: begin
          fast_q <= jump;
          if (jump) begin
            smoothed_q <= SmW'(r16);
          end else begin
            smoothed_q <= sm_next[SmW-1:0];
          end
          state_q <= S_CLAMP;
        end
        S_CLAMP: begin
          // Clamp the stored value to the current full scale before mapping
          r_q     <= (smoothed_q > full16) ? full16[DenW-1:0] : smoothed_q[DenW-1:0];
          pass_q  <= 1'b1;
          state_q <= S_MUL_A;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_target_q <= raw_q;
            out_speed_q  <= fast_q ? fast_speed_q : norm_speed_q;
            out_fast_q   <= fast_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.target_steps = out_target_q;
  assign out_o.move_speed   = out_speed_q;
  assign out_o.fast_move    = out_fast_q;

endmodule
